// File: design/assert_macros.svh
// assertion helpers used by feedforward_echo_comb
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define FFEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define FFEC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/ffec_pkg.sv
package ffec_pkg;

  // default sizes
  localparam int MAX_DELAY_DEF   = 65536;
  localparam int SAMPLE_BITS_DEF = 16;

  // register sizes
  localparam int TAP_W      = 17;
  localparam int ATT_W      = 15;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_ADDR_W = 1;

  localparam logic [TAP_W-1:0] TAP_RESET = TAP_W'(1);
  localparam logic [ATT_W-1:0] ATT_RESET = ATT_W'(16384);

  // q0.15 rounding
  localparam int FRAC_BITS  = 15;
  localparam int ROUND_HALF = 16384;

  // register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_TAP_LENGTH  = 1'b0,
    CFG_ATTENUATION = 1'b1
  } cfg_reg_t;

  // how the output is formed
  typedef enum logic [1:0] {
    MODE_ZERO = 2'b00,
    MODE_UNIT = 2'b01,
    MODE_ECHO = 2'b10
  } mode_t;

  // control carried with a sample down the pipeline
  typedef struct packed {
    mode_t mode;
    logic  hist_ok;
    logic  last;
  } s1_ctrl_t;

endpackage

// File: design/ffec_in_if.sv
interface ffec_in_if #(
  parameter int SAMPLE_BITS = ffec_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          last_in;

  modport source (output valid, output sample_in, output last_in, input ready);
  modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

// File: design/ffec_out_if.sv
interface ffec_out_if #(
  parameter int SAMPLE_BITS = ffec_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;
  logic                          last_out;

  modport source (output valid, output sample_out, output clipped, output last_out,
                  input ready);
  modport sink   (input valid, input sample_out, input clipped, input last_out,
                  output ready);
endinterface

// File: design/ffec_delay_mem.sv
module ffec_delay_mem #(
  parameter int DEPTH = ffec_pkg::MAX_DELAY_DEF,
  parameter int WIDTH = ffec_pkg::SAMPLE_BITS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  import ffec_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/ffec_echo_dp.sv
module ffec_echo_dp #(
  parameter int SAMPLE_BITS = ffec_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s1_valid,
  input  ffec_pkg::s1_ctrl_t            s1_ctrl,
  input  logic signed [SAMPLE_BITS-1:0] s1_sample,
  input  logic signed [SAMPLE_BITS-1:0] s1_delayed,
  input  logic [ffec_pkg::ATT_W-1:0]    attenuation,
  output logic                          s1_take,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_clipped,
  output logic                          out_last
);
  import ffec_pkg::*;

  localparam int PW = SAMPLE_BITS + 16;
  localparam int SW = SAMPLE_BITS + 2;
  localparam logic signed [SW-1:0] SAT_MAX = SW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SAT_MIN = -SAT_MAX - SW'(1);

  logic                          v2_r;
  s1_ctrl_t                      ctrl2_r;
  logic signed [SAMPLE_BITS-1:0] x2_r;
  logic signed [PW-1:0]          prod2_r;
  logic signed [PW-1:0]          prod_nxt;
  logic signed [PW-1:0]          d_ext;
  logic signed [PW-1:0]          a_ext;
  logic                          v3_r;
  logic signed [SAMPLE_BITS-1:0] y_r;
  logic                          clip_r;
  logic                          last_r;
  logic signed [SAMPLE_BITS-1:0] y_nxt;
  logic                          clip_nxt;
  logic signed [PW:0]            rnd;
  logic signed [SW-1:0]          term;
  logic signed [SW-1:0]          sum;
  logic                          en2;
  logic                          en3;

  // stage enables, bubbles collapse
  assign en3     = !v3_r || out_ready;
  assign en2     = !v2_r || en3;
  assign s1_take = en2;

  // echo product, delayed sample masked before the sound reached the tap
  assign d_ext    = s1_ctrl.hist_ok ? PW'(s1_delayed) : '0;
  assign a_ext    = PW'($signed({1'b0, attenuation}));
  assign prod_nxt = d_ext * a_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      ctrl2_r <= s1_ctrl;
      x2_r    <= s1_sample;
      prod2_r <= prod_nxt;
    end
  end

  // round to nearest, add and saturate
  assign rnd  = (PW + 1)'(prod2_r) + (PW + 1)'(ROUND_HALF);
  assign term = SW'(rnd >>> FRAC_BITS);
  assign sum  = SW'(x2_r) + term;

  always_comb begin
    y_nxt    = '0;
    clip_nxt = 1'b0;
    unique case (ctrl2_r.mode)
      MODE_ZERO: begin
        y_nxt = '0;
      end
      MODE_UNIT: begin
        y_nxt = x2_r;
      end
      MODE_ECHO: begin
        if (sum > SAT_MAX) begin
          y_nxt    = SAMPLE_BITS'(SAT_MAX);
          clip_nxt = 1'b1;
        end else if (sum < SAT_MIN) begin
          y_nxt    = SAMPLE_BITS'(SAT_MIN);
          clip_nxt = 1'b1;
        end else begin
          y_nxt = SAMPLE_BITS'(sum);
        end
      end
      default: begin
        y_nxt = '0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      y_r    <= y_nxt;
      clip_r <= clip_nxt;
      last_r <= ctrl2_r.last;
    end
  end

  assign out_valid   = v3_r;
  assign out_sample  = y_r;
  assign out_clipped = clip_r;
  assign out_last    = last_r;

endmodule

// File: design/feedforward_echo_comb.sv
// Feedforward echo comb filter for a stream of signed audio samples.
// in_ch carries sample_in and last_in; last_in marks the final sample of a
// sound, and the next transaction starts a new sound with empty history.
// out_ch carries sample_out = sample_in + attenuation * (sample tap_length-1
// back), rounded, saturated, with clipped set when saturation acted, and
// last_out copied from last_in. tap_length 0 gives zero, 1 passes the input.
// cfg_we/cfg_addr/cfg_wdata write tap_length (index 0) and attenuation
// (index 1, unsigned Q0.15); write them only while no transaction is in flight.
// A result passes stage 1 (memory read), stage 2 (product) and the output
// register before it is presented. Throughput: one transaction per cycle
// while out_ch takes results, as the delay line is written and read together.
// Reset (synchronous, rst_n low) clears pipeline valids, the write pointer,
// the sample count and loads the register defaults; the delay line itself
// is not cleared, since history before a sound's start is masked by count.
// When out_ch stalls, the output register holds its result and the two
// stages behind it keep filling; in_ch.ready drops only once all are full.
module feedforward_echo_comb #(
  parameter int MAX_DELAY   = ffec_pkg::MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = ffec_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ffec_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ffec_pkg::CFG_DATA_W-1:0] cfg_wdata,
  ffec_in_if.sink                         in_ch,
  ffec_out_if.source                      out_ch
);
  import ffec_pkg::*;
  `include "assert_macros.svh"

  localparam int AW = $clog2(MAX_DELAY);
  localparam int CW = $clog2(MAX_DELAY + 1);
  localparam int LW = (CW > TAP_W) ? CW : TAP_W;
  localparam logic [LW-1:0] MAX_L   = LW'(MAX_DELAY);
  localparam logic [AW:0]   DEPTH_E = (AW + 1)'(MAX_DELAY);
  localparam logic [AW-1:0] WP_LAST = AW'(MAX_DELAY - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_DELAY);

  logic [TAP_W-1:0]              tap_length_r;
  logic [ATT_W-1:0]              attenuation_r;
  logic [AW-1:0]                 wp_r;
  logic [AW-1:0]                 wp_nxt;
  logic [CW-1:0]                 count_r;
  logic [CW-1:0]                 count_nxt;
  logic                          v1_r;
  s1_ctrl_t                      ctrl1_r;
  s1_ctrl_t                      ctrl_nxt;
  logic signed [SAMPLE_BITS-1:0] x1_r;
  logic [SAMPLE_BITS-1:0]        rd_data;
  logic                          en1;
  logic                          s1_take;
  logic                          accept;
  logic [LW-1:0]                 len;
  logic [LW-1:0]                 k;
  logic [AW:0]                   diff;
  logic [AW-1:0]                 raddr;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_length_r  <= TAP_RESET;
      attenuation_r <= ATT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TAP_LENGTH:  tap_length_r  <= cfg_wdata[TAP_W-1:0];
        CFG_ATTENUATION: attenuation_r <= cfg_wdata[ATT_W-1:0];
        default: ;
      endcase
    end
  end

  // input handshake
  assign en1         = !v1_r || s1_take;
  assign accept      = in_ch.valid && en1;
  assign in_ch.ready = en1;

  // effective tap and read address of the echo sample
  assign len  = (LW'(tap_length_r) > MAX_L) ? MAX_L : LW'(tap_length_r);
  assign k    = len - LW'(1);
  assign diff = {1'b0, wp_r} - {1'b0, k[AW-1:0]};
  assign raddr = diff[AW] ? AW'(diff + DEPTH_E) : diff[AW-1:0];

  always_comb begin
    ctrl_nxt.hist_ok = LW'(count_r) >= k;
    ctrl_nxt.last    = in_ch.last_in;
    if (len == '0) begin
      ctrl_nxt.mode = MODE_ZERO;
    end else if (len == LW'(1)) begin
      ctrl_nxt.mode = MODE_UNIT;
    end else begin
      ctrl_nxt.mode = MODE_ECHO;
    end
  end

  // ring pointer and per-sound sample count
  assign wp_nxt = (wp_r == WP_LAST) ? '0 : wp_r + AW'(1);

  always_comb begin
    if (in_ch.last_in) begin
      count_nxt = '0;
    end else if (count_r < CNT_MAX) begin
      count_nxt = count_r + CW'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      count_r <= '0;
    end else if (accept) begin
      wp_r    <= wp_nxt;
      count_r <= count_nxt;
    end
  end

  // stage 1: memory read in flight alongside the sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ctrl1_r <= ctrl_nxt;
      x1_r    <= in_ch.sample_in;
    end
  end

  // every accepted sample is written; reads see earlier writes directly
  ffec_delay_mem #(
    .DEPTH (MAX_DELAY),
    .WIDTH (SAMPLE_BITS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (accept),
    .waddr (wp_r),
    .wdata (in_ch.sample_in),
    .re    (en1),
    .raddr (raddr),
    .rdata (rd_data)
  );

  ffec_echo_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_valid    (v1_r),
    .s1_ctrl     (ctrl1_r),
    .s1_sample   (x1_r),
    .s1_delayed  ($signed(rd_data)),
    .attenuation (attenuation_r),
    .s1_take     (s1_take),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_sample  (out_ch.sample_out),
    .out_clipped (out_ch.clipped),
    .out_last    (out_ch.last_out)
  );

  // checks
  `FFEC_ASSERT(a_ready_when_out_empty, !out_ch.valid |-> in_ch.ready, "input stalled with empty output")
  `FFEC_ASSERT(a_wp_range, wp_r <= WP_LAST, "write pointer out of range")
  `FFEC_ASSERT(a_last_clears_count, accept && in_ch.last_in |=> count_r == '0, "count not cleared")
  `FFEC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_ch.valid, "output valid after reset")

endmodule
